// ===== hdl/bpas_pkg.sv =====
`default_nettype none

package bpas_pkg;

  localparam int T_BITS       = 16;
  localparam int TW           = T_BITS + 1;
  localparam int COORD_BITS   = 24;
  localparam int DW           = COORD_BITS + 1;
  localparam int SQW          = 2 * COORD_BITS + 1;
  localparam int RW           = SQW + 1;
  localparam int MW           = COORD_BITS + 2;
  localparam int PW           = 2 * MW;
  localparam int PTW          = 2 * COORD_BITS;
  localparam int LW           = 24;
  localparam int SCW          = 24;
  localparam int TOLW         = 16;
  localparam int SCALE_FRAC   = 16;
  localparam int DIV_STEPS    = LW + T_BITS;
  localparam int MAX_ITER_DEF = 24;

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_BITS;

  localparam logic [2:0] REG_ORDER = 3'd0;
  localparam logic [2:0] REG_CP0   = 3'd1;
  localparam logic [2:0] REG_CP1   = 3'd2;
  localparam logic [2:0] REG_CP2   = 3'd3;
  localparam logic [2:0] REG_CP3   = 3'd4;
  localparam logic [2:0] REG_SCALE = 3'd5;
  localparam logic [2:0] REG_TOL   = 3'd6;

  localparam logic [1:0] ACT_EVAL  = 2'd0;
  localparam logic [1:0] ACT_CHORD = 2'd1;
  localparam logic [1:0] ACT_HORZ  = 2'd2;

  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_END    = 2'd1;
  localparam logic [1:0] ST_FAIL   = 2'd2;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_ELOAD = 16'h0002,
    S_MUL   = 16'h0004,
    S_ACC   = 16'h0008,
    S_SMUL  = 16'h0010,
    S_SACC  = 16'h0020,
    S_DLOAD = 16'h0040,
    S_SQ    = 16'h0080,
    S_SQA   = 16'h0100,
    S_SQRT  = 16'h0200,
    S_DIV   = 16'h0400,
    S_LTM   = 16'h0800,
    S_LTA   = 16'h1000,
    S_CHK   = 16'h2000,
    S_NEXT  = 16'h4000,
    S_OUT   = 16'h8000
  } state_t;

  typedef enum logic [9:0] {
    P_EVAL   = 10'h001,
    P_BEG    = 10'h002,
    P_END    = 10'h004,
    P_TOEND  = 10'h008,
    P_LSTART = 10'h010,
    P_LLEN   = 10'h020,
    P_LDIV   = 10'h040,
    P_LPT    = 10'h080,
    P_SEVAL  = 10'h100,
    P_SDIST  = 10'h200
  } phase_t;

endpackage

`default_nettype wire

// ===== hdl/bezier_point_and_arc_step.sv =====
// An evaluate item runs one evaluation of the curve at t. A distance step first evaluates t
// and the curve end and measures one distance; then each bisection try costs one evaluation
// plus one distance, up to MAX_ITER tries. A linear chord step skips the bisection: it
// evaluates the curve start, measures the chord length and does a restoring divide.
// One item at a time, set by the shared
// multiplier and the bit-serial square root. Reset: rst is synchronous; it empties the block.
`default_nettype none

module bezier_point_and_arc_step
  import bpas_pkg::*;
#(
  parameter int MAX_ITER = MAX_ITER_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // t_start, step_distance
  input  logic [1:0]  s_tuser,   // action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // t_result, point_x, point_y, remaining
  output logic [1:0]  m_tuser,   // status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int IW = $clog2(MAX_ITER + 1);
  localparam int CNTW = $clog2(DIV_STEPS);
  localparam int CW = COORD_BITS;

  logic [1:0]     order;
  logic [PTW-1:0] cp [4];
  logic [SCW-1:0] scale;
  logic [TOLW-1:0] tol;

  state_t state;
  phase_t phase;

  logic [TW-1:0] tq, et;
  logic [LW-1:0] l;
  logic          horz;
  logic signed [CW-1:0] xs [4];
  logic signed [CW-1:0] ys [4];
  logic [1:0] lvl, idx;
  logic       axis;
  logic signed [CW-1:0] qx, qy, bx, by, ex, ey, ux, uy, vx, vy;
  logic [CW-1:0]  dx, dy;
  logic [PTW-1:0] sq;
  logic [SQW-1:0] sqr;
  logic [RW-1:0]  res, bitv;
  logic [DW-1:0]  dreg;
  logic [DIV_STEPS-1:0] dq;
  logic [DW-1:0]  dr;
  logic [CNTW-1:0] cnt;
  logic [LW-1:0]  lt;
  logic [TW-1:0]  dtmin, dtmax, dt, lastdt;
  logic           lastv;
  logic [IW-1:0]  iter;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod, rnd;

  logic [1:0]    r_status, o_status;
  logic [TW-1:0] r_tres, o_tres;
  logic [CW-1:0] r_px, r_py, o_px, o_py;
  logic [LW-1:0] r_rem, o_rem;

  logic [1:0] idxp, eff_order;
  logic signed [CW:0] xdiff, ydiff, udx, udy;
  logic [CW-1:0] satv;
  logic [RW-1:0] trial, res_n;
  logic          ge;
  logic [DW:0]   rem2;
  logic [DIV_STEPS:0] lsum;
  logic [TW-1:0] ltr, nmin, nmax;
  logic [DW-1:0] err;
  logic [TW-1:0] tin;

  assign s_tready  = (state == S_IDLE);
  assign m_tdata   = {7'd0, o_rem, o_py, o_px, o_tres};
  assign m_tuser   = o_status;
  assign eff_order = (order == 2'd0) ? 2'd1 : order;
  assign idxp      = idx + 2'd1;
  assign xdiff     = {xs[idxp][CW-1], xs[idxp]} - {xs[idx][CW-1], xs[idx]};
  assign ydiff     = {ys[idxp][CW-1], ys[idxp]} - {ys[idx][CW-1], ys[idx]};
  assign udx       = {ux[CW-1], ux} - {vx[CW-1], vx};
  assign udy       = {uy[CW-1], uy} - {vy[CW-1], vy};
  assign rnd       = (prod + PW'(signed'(33'sd32768))) >>> SCALE_FRAC;
  assign satv      = (rnd > PW'(signed'(33'sd8388607))) ? {1'b0, {(CW-1){1'b1}}} :
                     (rnd < -PW'(signed'(33'sd8388608))) ? {1'b1, {(CW-1){1'b0}}} :
                     rnd[CW-1:0];
  assign trial     = res + bitv;
  assign ge        = {1'b0, sqr} >= trial;
  assign res_n     = ge ? ((res >> 1) + bitv) : (res >> 1);
  assign rem2      = {dr, dq[DIV_STEPS-1]};
  assign lsum      = (DIV_STEPS + 1)'(dq) + (DIV_STEPS + 1)'(tq);
  assign ltr       = (lsum > (DIV_STEPS + 1)'(T_ONE)) ? T_ONE : lsum[TW-1:0];
  assign err       = (dreg > DW'(l)) ? (dreg - DW'(l)) : (DW'(l) - dreg);
  assign nmin      = (dreg > DW'(l)) ? dtmin : dt;
  assign nmax      = (dreg > DW'(l)) ? dt : dtmax;
  assign tin       = (s_tdata[TW-1:0] > T_ONE) ? T_ONE : s_tdata[TW-1:0];

  always_comb begin
    unique case (state)
      S_MUL: begin
        ma = MW'(axis ? ydiff : xdiff);
        mb = MW'(et);
      end
      S_SMUL: begin
        ma = MW'(axis ? ys[0] : xs[0]);
        mb = MW'(scale);
      end
      S_SQ: begin
        ma = MW'(axis ? dy : dx);
        mb = MW'(axis ? dy : dx);
      end
      S_LTM: begin
        ma = MW'(tol);
        mb = MW'(l);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 2'd3;
      cp[0] <= '0;
      cp[1] <= '0;
      cp[2] <= '0;
      cp[3] <= '0;
      scale <= SCW'(65536);
      tol   <= TOLW'(655);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ORDER: order <= cfg_data[1:0];
        REG_CP0:   cp[0] <= cfg_data;
        REG_CP1:   cp[1] <= cfg_data;
        REG_CP2:   cp[2] <= cfg_data;
        REG_CP3:   cp[3] <= cfg_data;
        REG_SCALE: scale <= cfg_data[SCW-1:0];
        REG_TOL:   tol   <= cfg_data[TOLW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
    if (rst) begin
      state    <= S_IDLE;
      phase    <= P_EVAL;
      m_tvalid <= 1'b0;
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        o_status <= r_status;
        o_tres   <= r_tres;
        o_px     <= r_px;
        o_py     <= r_py;
        o_rem    <= r_rem;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            tq   <= tin;
            et   <= tin;
            l    <= s_tdata[TW+LW-1:TW];
            horz <= (s_tuser == ACT_HORZ);
            phase <= (s_tuser == ACT_CHORD || s_tuser == ACT_HORZ) ? P_BEG : P_EVAL;
            state <= S_ELOAD;
          end
        end
        S_ELOAD: begin
          for (int i = 0; i < 4; i++) begin
            xs[i] <= cp[i][PTW-1:CW];
            ys[i] <= cp[i][CW-1:0];
          end
          lvl   <= eff_order;
          idx   <= 2'd0;
          axis  <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          if (!axis) begin
            xs[idx] <= xs[idx] + rnd[CW-1:0];
            axis    <= 1'b1;
            state   <= S_MUL;
          end else begin
            ys[idx] <= ys[idx] + rnd[CW-1:0];
            axis    <= 1'b0;
            if (idxp < lvl) begin
              idx   <= idxp;
              state <= S_MUL;
            end else begin
              idx <= 2'd0;
              if (lvl == 2'd1) begin
                state <= S_SMUL;
              end else begin
                lvl   <= lvl - 2'd1;
                state <= S_MUL;
              end
            end
          end
        end
        S_SMUL: state <= S_SACC;
        S_SACC: begin
          if (!axis) begin
            qx    <= satv;
            axis  <= 1'b1;
            state <= S_SMUL;
          end else begin
            qy    <= satv;
            axis  <= 1'b0;
            state <= S_NEXT;
          end
        end
        S_DLOAD: begin
          dx   <= udx[CW] ? CW'(-udx) : udx[CW-1:0];
          dy   <= udy[CW] ? CW'(-udy) : udy[CW-1:0];
          axis <= 1'b0;
          if (horz) begin
            dreg  <= udx[CW] ? DW'(-udx) : DW'(udx);
            state <= S_NEXT;
          end else begin
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_SQA;
        S_SQA: begin
          if (!axis) begin
            sq    <= prod[PTW-1:0];
            axis  <= 1'b1;
            state <= S_SQ;
          end else begin
            sqr   <= SQW'(sq) + SQW'(prod[PTW-1:0]);
            res   <= '0;
            bitv  <= RW'(1) << (SQW - 1);
            axis  <= 1'b0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (ge) sqr <= sqr - trial[SQW-1:0];
          res  <= res_n;
          bitv <= bitv >> 2;
          if (bitv[0]) begin
            dreg  <= res_n[DW-1:0];
            state <= S_NEXT;
          end
        end
        S_DIV: begin
          if (rem2 >= {1'b0, dreg}) begin
            dr <= DW'(rem2 - {1'b0, dreg});
            dq <= {dq[DIV_STEPS-2:0], 1'b1};
          end else begin
            dr <= rem2[DW-1:0];
            dq <= {dq[DIV_STEPS-2:0], 1'b0};
          end
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(DIV_STEPS - 1)) state <= S_NEXT;
        end
        S_LTM: state <= S_LTA;
        S_LTA: begin
          lt    <= prod[LW+15:16];
          dtmin <= '0;
          dtmax <= T_ONE - tq;
          dt    <= (T_ONE - tq) >> 1;
          lastv <= 1'b0;
          iter  <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (iter < IW'(MAX_ITER) && !(horz && lastv && lastdt == dt)) begin
            iter  <= iter + IW'(1);
            et    <= tq + dt;
            phase <= P_SEVAL;
            state <= S_ELOAD;
          end else begin
            r_status <= ST_FAIL;
            r_tres   <= tq;
            r_px     <= '0;
            r_py     <= '0;
            r_rem    <= '0;
            state    <= S_OUT;
          end
        end
        S_NEXT: begin
          unique case (phase)
            P_EVAL, P_LPT: begin
              r_status <= ST_FOUND;
              if (phase == P_EVAL) r_tres <= tq;
              r_px  <= qx;
              r_py  <= qy;
              r_rem <= '0;
              state <= S_OUT;
            end
            P_BEG: begin
              bx    <= qx;
              by    <= qy;
              et    <= T_ONE;
              phase <= P_END;
              state <= S_ELOAD;
            end
            P_END: begin
              ex    <= qx;
              ey    <= qy;
              ux    <= bx;
              uy    <= by;
              vx    <= qx;
              vy    <= qy;
              phase <= P_TOEND;
              state <= S_DLOAD;
            end
            P_TOEND: begin
              if (dreg < DW'(l)) begin
                r_status <= ST_END;
                r_tres   <= tq;
                r_px     <= '0;
                r_py     <= '0;
                r_rem    <= dreg[DW-1] ? {LW{1'b1}} : dreg[LW-1:0];
                state    <= S_OUT;
              end else if (!horz && eff_order == 2'd1) begin
                et    <= '0;
                phase <= P_LSTART;
                state <= S_ELOAD;
              end else begin
                state <= S_LTM;
              end
            end
            P_LSTART: begin
              ux    <= qx;
              uy    <= qy;
              vx    <= ex;
              vy    <= ey;
              phase <= P_LLEN;
              state <= S_DLOAD;
            end
            P_LLEN: begin
              if (dreg != '0) begin
                dq    <= {l, {T_BITS{1'b0}}};
                dr    <= '0;
                cnt   <= '0;
                phase <= P_LDIV;
                state <= S_DIV;
              end else begin
                et     <= tq;
                r_tres <= tq;
                phase  <= P_LPT;
                state  <= S_ELOAD;
              end
            end
            P_LDIV: begin
              et     <= ltr;
              r_tres <= ltr;
              phase  <= P_LPT;
              state  <= S_ELOAD;
            end
            P_SEVAL: begin
              ux    <= bx;
              uy    <= by;
              vx    <= qx;
              vy    <= qy;
              phase <= P_SDIST;
              state <= S_DLOAD;
            end
            P_SDIST: begin
              if (err < DW'(lt)) begin
                r_status <= ST_FOUND;
                r_tres   <= tq + dt;
                r_px     <= qx;
                r_py     <= qy;
                r_rem    <= '0;
                state    <= S_OUT;
              end else begin
                dtmin  <= nmin;
                dtmax  <= nmax;
                lastdt <= dt;
                lastv  <= 1'b1;
                dt     <= nmin + ((nmax - nmin) >> 1);
                state  <= S_CHK;
              end
            end
            default: state <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_point_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_FOUND) |-> (m_tdata[64:17] == '0))
    else $error("point fields must be zero unless a point was found");
  a_rem_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_END) |-> (m_tdata[88:65] == '0))
    else $error("remaining must be zero unless the end was reached");
  a_bracket: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHK) |-> (dtmin <= dt) && (dt <= dtmax) && (tq + dt <= T_ONE))
    else $error("bisection step left its bracket");
  a_tres: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[16:0] <= T_ONE))
    else $error("t_result above one");
`endif

endmodule

`default_nettype wire
